/* design/abtv_pkg.sv */
// Shared types, codes and constants for the arcade board bus and tile video unit.
// No dependencies; the design files but the channel interfaces and abtv_ram refer to it by scoped names.

package abtv_pkg;

  // Screen limits for the pixel request
  localparam int unsigned ScreenWidth  = 256;
  localparam int unsigned ScreenHeight = 256;

  // Store depths and address widths
  localparam int unsigned RomDepth  = 8192;
  localparam int unsigned PatDepth  = 4096;
  localparam int unsigned BankDepth = 1024;
  localparam int unsigned RomAw     = $clog2(RomDepth);
  localparam int unsigned PatAw     = $clog2(PatDepth);
  localparam int unsigned BankAw    = $clog2(BankDepth);
  localparam int unsigned NumBanks  = 4;

  // Configuration port address width
  localparam int unsigned CfgAw = 3;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_MEM_RD   = 3'd0,
    KIND_MEM_WR   = 3'd1,
    KIND_IO_IN    = 3'd2,
    KIND_IO_OUT   = 3'd3,
    KIND_ROM_LOAD = 3'd4,
    KIND_PAT_LOAD = 3'd5,
    KIND_PIXEL    = 3'd6
  } kind_e;

  // I/O port numbers
  localparam logic [7:0] PORT_P1      = 8'd0;
  localparam logic [7:0] PORT_P2      = 8'd1;
  localparam logic [7:0] PORT_DIP     = 8'd2;
  localparam logic [7:0] PORT_COIN    = 8'd3;
  localparam logic [7:0] PORT_PALETTE = 8'd4;
  localparam logic [7:0] PORT_MELODY  = 8'd5;
  localparam logic [7:0] PORT_NOISE   = 8'd6;
  localparam logic [7:0] PORT_CONTROL = 8'd7;

  // Memory map: RAM banks live in the 4 KB page at 0x4000, selected by bits 11:10
  localparam logic [3:0] BANK_PAGE = 4'h4;
  localparam logic [1:0] BANK_FG   = 2'd0;
  localparam logic [1:0] BANK_BG   = 2'd1;
  localparam logic [1:0] BANK_COL  = 2'd2;
  localparam logic [1:0] BANK_WORK = 2'd3;

  // Register indexes of the configuration port
  localparam logic REG_DIP = 1'b0;

  localparam logic [7:0] UNMAPPED  = 8'hFF;
  localparam logic [7:0] ROM_FILL  = 8'hFF;
  localparam logic [7:0] PAL_LEVEL = 8'hAA;

  // One input word
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  port;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  p1_buttons;
    logic [7:0]  p2_buttons;
    logic [7:0]  coin_inputs;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic [7:0]  read_data;
    logic [23:0] pixel_color;
    logic        irq_en;
    logic [3:0]  scroll_ofs;
    logic [7:0]  palette_select;
    logic [7:0]  melody_code;
    logic [7:0]  noise_code;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic capture;
    logic pat_read;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic in_pixel;
  } dp_status_t;

  // Fixed 8-entry palette: bit 2 red, bit 1 green, bit 0 blue
  function automatic logic [23:0] palette_rgb(input logic [2:0] idx);
    palette_rgb = {idx[2] ? PAL_LEVEL : 8'h00,
                   idx[1] ? PAL_LEVEL : 8'h00,
                   idx[0] ? PAL_LEVEL : 8'h00};
  endfunction

endpackage

/* design/abtv_in_if.sv */
// Input channel of the bus and tile video unit: valid/ready and the request fields.
// No dependencies.

interface abtv_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  port;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [7:0]  p1_buttons;
  logic [7:0]  p2_buttons;
  logic [7:0]  coin_inputs;

  modport source (
    output valid, kind, address, data, port, pixel_x, pixel_y,
           p1_buttons, p2_buttons, coin_inputs,
    input  ready
  );

  modport sink (
    input  valid, kind, address, data, port, pixel_x, pixel_y,
           p1_buttons, p2_buttons, coin_inputs,
    output ready
  );
endinterface

/* design/abtv_out_if.sv */
// Output channel of the bus and tile video unit: valid/ready and the result fields.
// No dependencies.

interface abtv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [23:0] pixel_color;
  logic        irq_en;
  logic [3:0]  scroll_ofs;
  logic [7:0]  palette_select;
  logic [7:0]  melody_code;
  logic [7:0]  noise_code;

  modport source (
    output valid, read_data, pixel_color, irq_en, scroll_ofs,
           palette_select, melody_code, noise_code,
    input  ready
  );

  modport sink (
    input  valid, read_data, pixel_color, irq_en, scroll_ofs,
           palette_select, melody_code, noise_code,
    output ready
  );
endinterface

/* design/abtv_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module abtv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/abtv_apb_regs.sv */
// Configuration register block: APB-style write/read of the DIP switch byte.
// Depends on abtv_pkg.

module abtv_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [abtv_pkg::CfgAw-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [7:0]                 dip_o
);

  logic       dip_hit;
  logic [7:0] dip_q;
  logic [7:0] dip_d;

  // Decode the register index from the word address
  assign dip_hit = (paddr[2] == abtv_pkg::REG_DIP);
  assign pready  = 1'b1;

  // Take the byte on a completed write access
  always_comb begin
    dip_d = dip_q;
    if (psel && penable && pwrite && dip_hit) begin
      dip_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_q <= '0;
    end else begin
      dip_q <= dip_d;
    end
  end

  assign prdata = dip_hit ? {24'h0, dip_q} : 32'h0;
  assign dip_o  = dip_q;

endmodule

/* design/abtv_datapath.sv */
// Datapath: ROM, RAM banks, pattern ROM, port latches, item registers and the
// result register. Depends on abtv_pkg and abtv_ram; driven by abtv_ctrl.

module abtv_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  abtv_pkg::ctrl_cmd_t    cmd_i,
  output abtv_pkg::dp_status_t   status_o,
  input  abtv_pkg::in_item_t     item_i,
  input  logic [7:0]             dip_i,
  output abtv_pkg::out_item_t    result_o
);

  localparam int unsigned RomAw  = abtv_pkg::RomAw;
  localparam int unsigned PatAw  = abtv_pkg::PatAw;
  localparam int unsigned BankAw = abtv_pkg::BankAw;

  // Clearing sweep
  logic [RomAw-1:0] clr_cnt_q;
  logic [RomAw-1:0] clr_cnt_d;

  // Port latches
  logic       irq_q, irq_d;
  logic [3:0] scroll_q, scroll_d;
  logic [7:0] pal_q, pal_d;
  logic [7:0] mel_q, mel_d;
  logic [7:0] noise_q, noise_d;

  // Captured item
  logic [2:0]  kind_q;
  logic [15:0] addr_q;
  logic [7:0]  io_rd_q;
  logic [2:0]  xbit_q;
  logic [2:0]  yrow_q;
  logic        on_scr_q;
  logic [7:0]  io_rd;
  logic        on_scr;
  logic        in_pixel;

  // Memory signals
  logic             rom_we;
  logic [RomAw-1:0] rom_waddr;
  logic [7:0]       rom_wdata;
  logic [7:0]       rom_rdata;
  logic             pat_we;
  logic [PatAw-1:0] pat_waddr;
  logic [7:0]       pat_wdata;
  logic [PatAw-1:0] pat_raddr;
  logic [7:0]       pat_rdata;
  logic [7:0]       bank_rdata [abtv_pkg::NumBanks];
  logic             bank_page_wr;

  // Result
  logic [7:0]           mem_rd;
  logic                 pix_bit;
  logic [2:0]           pix_idx;
  abtv_pkg::out_item_t  result_d;
  abtv_pkg::out_item_t  result_q;

  assign in_pixel = (item_i.kind == abtv_pkg::KIND_PIXEL);
  assign on_scr   = ({1'b0, item_i.pixel_x} < 9'(abtv_pkg::ScreenWidth)) &&
                    ({1'b0, item_i.pixel_y} < 9'(abtv_pkg::ScreenHeight));

  assign status_o.clear_last = &clr_cnt_q;
  assign status_o.in_pixel   = in_pixel;

  // Advance the clearing sweep
  assign clr_cnt_d = cmd_i.clear ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Input port read, sampled with the item
  always_comb begin
    unique case (item_i.port)
      abtv_pkg::PORT_P1:   io_rd = ~item_i.p1_buttons;
      abtv_pkg::PORT_P2:   io_rd = ~item_i.p2_buttons;
      abtv_pkg::PORT_DIP:  io_rd = dip_i;
      abtv_pkg::PORT_COIN: io_rd = item_i.coin_inputs;
      default:             io_rd = abtv_pkg::UNMAPPED;
    endcase
  end

  // Output port latches
  always_comb begin
    irq_d    = irq_q;
    scroll_d = scroll_q;
    pal_d    = pal_q;
    mel_d    = mel_q;
    noise_d  = noise_q;
    if (cmd_i.capture && item_i.kind == abtv_pkg::KIND_IO_OUT) begin
      unique case (item_i.port)
        abtv_pkg::PORT_PALETTE: pal_d = item_i.data;
        abtv_pkg::PORT_MELODY:  mel_d = item_i.data;
        abtv_pkg::PORT_NOISE:   noise_d = item_i.data;
        abtv_pkg::PORT_CONTROL: begin
          irq_d    = item_i.data[0];
          scroll_d = item_i.data[4:1];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_q    <= 1'b0;
      scroll_q <= '0;
      pal_q    <= '0;
      mel_q    <= '0;
      noise_q  <= '0;
    end else begin
      irq_q    <= irq_d;
      scroll_q <= scroll_d;
      pal_q    <= pal_d;
      mel_q    <= mel_d;
      noise_q  <= noise_d;
    end
  end

  // Hold the fields needed after the memory reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= item_i.kind;
      addr_q   <= item_i.address;
      io_rd_q  <= io_rd;
      xbit_q   <= item_i.pixel_x[2:0];
      yrow_q   <= item_i.pixel_y[2:0];
      on_scr_q <= on_scr;
    end
  end

  // Program ROM: cleared to 0xFF, filled by ROM loads
  assign rom_we    = cmd_i.clear ||
                     (cmd_i.capture && item_i.kind == abtv_pkg::KIND_ROM_LOAD &&
                      item_i.address[15:RomAw] == '0);
  assign rom_waddr = cmd_i.clear ? clr_cnt_q : item_i.address[RomAw-1:0];
  assign rom_wdata = cmd_i.clear ? abtv_pkg::ROM_FILL : item_i.data;

  abtv_ram #(
    .Width (8),
    .Depth (abtv_pkg::RomDepth)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (rom_we),
    .waddr_i (rom_waddr),
    .wdata_i (rom_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (item_i.address[RomAw-1:0]),
    .rdata_o (rom_rdata)
  );

  // Pattern ROM: cleared to zero, filled by pattern loads, read with the tile code
  assign pat_we    = cmd_i.clear ||
                     (cmd_i.capture && item_i.kind == abtv_pkg::KIND_PAT_LOAD &&
                      item_i.address[15:PatAw] == '0);
  assign pat_waddr = cmd_i.clear ? clr_cnt_q[PatAw-1:0] : item_i.address[PatAw-1:0];
  assign pat_wdata = cmd_i.clear ? 8'h00 : item_i.data;
  assign pat_raddr = PatAw'({bank_rdata[abtv_pkg::BANK_FG], yrow_q});

  abtv_ram #(
    .Width (8),
    .Depth (abtv_pkg::PatDepth)
  ) u_pat (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .re_i    (cmd_i.pat_read),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // RAM banks: foreground map, background map, colour RAM, work RAM
  assign bank_page_wr = cmd_i.capture && item_i.kind == abtv_pkg::KIND_MEM_WR &&
                        item_i.address[15:12] == abtv_pkg::BANK_PAGE;

  for (genvar b = 0; b < abtv_pkg::NumBanks; b++) begin : g_bank
    logic              we;
    logic [BankAw-1:0] waddr;
    logic [7:0]        wdata;
    logic [BankAw-1:0] raddr;

    assign we    = cmd_i.clear ||
                   (bank_page_wr && item_i.address[11:10] == 2'(b));
    assign waddr = cmd_i.clear ? clr_cnt_q[BankAw-1:0] : item_i.address[BankAw-1:0];
    assign wdata = cmd_i.clear ? 8'h00 : item_i.data;

    // Pixel reads take the tile cell from the map and the column attribute
    if (2'(b) == abtv_pkg::BANK_FG) begin : g_fg
      assign raddr = in_pixel ? {item_i.pixel_y[7:3], item_i.pixel_x[7:3]}
                              : item_i.address[BankAw-1:0];
    end else if (2'(b) == abtv_pkg::BANK_COL) begin : g_col
      assign raddr = in_pixel ? BankAw'(item_i.pixel_x[7:3])
                              : item_i.address[BankAw-1:0];
    end else begin : g_plain
      assign raddr = item_i.address[BankAw-1:0];
    end

    abtv_ram #(
      .Width (8),
      .Depth (abtv_pkg::BankDepth)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (cmd_i.capture),
      .raddr_i (raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  // Decode the memory read
  always_comb begin
    if (addr_q[15:RomAw] == '0) begin
      mem_rd = rom_rdata;
    end else if (addr_q[15:12] == abtv_pkg::BANK_PAGE) begin
      mem_rd = bank_rdata[addr_q[11:10]];
    end else begin
      mem_rd = abtv_pkg::UNMAPPED;
    end
  end

  // Pick ink or paper from the pattern bit
  assign pix_bit = pat_rdata[~xbit_q];
  assign pix_idx = pix_bit ? bank_rdata[abtv_pkg::BANK_COL][2:0]
                           : bank_rdata[abtv_pkg::BANK_COL][6:4];

  // Assemble the result word
  always_comb begin
    result_d                = '0;
    result_d.irq_en         = irq_q;
    result_d.scroll_ofs     = scroll_q;
    result_d.palette_select = pal_q;
    result_d.melody_code    = mel_q;
    result_d.noise_code     = noise_q;
    unique case (kind_q)
      abtv_pkg::KIND_MEM_RD: result_d.read_data = mem_rd;
      abtv_pkg::KIND_IO_IN:  result_d.read_data = io_rd_q;
      abtv_pkg::KIND_PIXEL:  result_d.pixel_color =
                               on_scr_q ? abtv_pkg::palette_rgb(pix_idx) : 24'h0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

/* design/abtv_ctrl.sv */
// Controller: clearing sweep, item sequencing and the output word handshake.
// Depends on abtv_pkg; commands abtv_datapath.

module abtv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  abtv_pkg::dp_status_t status_i,
  output abtv_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TILE,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Commands from the current state
  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.clear    = (state_q == ST_CLEAR);
  assign cmd_o.capture  = in_ready_o && in_valid_i;
  assign cmd_o.pat_read = (state_q == ST_TILE);
  assign cmd_o.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= status_i.in_pixel ? ST_TILE : ST_DONE;
          end
        end
        ST_TILE: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (cmd_o.load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase

      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A pixel needs the pattern read before its result is formed
  a_pixel_two_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture && status_i.in_pixel |=> !cmd_o.load_out)
    else $error("pixel result loaded before pattern read");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // A waiting result stays until taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped while stalled");

  // One item in flight at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o)
    else $error("second item taken while one is in flight");
`endif

endmodule

/* design/arcade_board_bus_and_tile_video_unit.sv */
// Bus decoder and foreground tile video of an 8080-based arcade board. After reset
// the unit sweeps its memories (program ROM to 0xFF, RAM banks and pattern ROM to zero)
// and takes no word until the sweep ends; configuration writes are taken throughout.
// Items are handled one at a time: memory, I/O and load words go from acceptance to
// the result state, a pixel first passes a tile state, since the tile code from the
// foreground map must come out of its RAM before the pattern ROM can be read.
// A result register lets the next word enter while a result waits to be taken.
// Depends on abtv_pkg, the channel interfaces, abtv_apb_regs, abtv_ctrl, abtv_datapath.

module arcade_board_bus_and_tile_video_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  abtv_in_if.sink                    in_i,
  abtv_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [abtv_pkg::CfgAw-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  abtv_pkg::in_item_t   item;
  abtv_pkg::out_item_t  result;
  abtv_pkg::ctrl_cmd_t  cmd;
  abtv_pkg::dp_status_t status;
  logic [7:0]           dip;

  // Gather the input word
  assign item.kind        = in_i.kind;
  assign item.address     = in_i.address;
  assign item.data        = in_i.data;
  assign item.port        = in_i.port;
  assign item.pixel_x     = in_i.pixel_x;
  assign item.pixel_y     = in_i.pixel_y;
  assign item.p1_buttons  = in_i.p1_buttons;
  assign item.p2_buttons  = in_i.p2_buttons;
  assign item.coin_inputs = in_i.coin_inputs;

  abtv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dip_o   (dip)
  );

  abtv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  abtv_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .item_i   (item),
    .dip_i    (dip),
    .result_o (result)
  );

  // Spread the result word over the channel
  assign out_o.read_data      = result.read_data;
  assign out_o.pixel_color    = result.pixel_color;
  assign out_o.irq_en         = result.irq_en;
  assign out_o.scroll_ofs     = result.scroll_ofs;
  assign out_o.palette_select = result.palette_select;
  assign out_o.melody_code    = result.melody_code;
  assign out_o.noise_code     = result.noise_code;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the arcade board bus and tile video unit.
// Depends on abtv_pkg, abtv_in_if, abtv_out_if and the unit's top level.
// Drives request words, predicts each result word and compares field by field.
`timescale 1ns / 1ps

// Ledger of the board: a predictor of memories, latches and DIP byte,
// plus the queue of result words still owed by the unit
class bus_video_ledger;
  logic [7:0]  rom_bytes [abtv_pkg::RomDepth];
  logic [7:0]  fg_map    [abtv_pkg::BankDepth];
  logic [7:0]  bg_map    [abtv_pkg::BankDepth];
  logic [7:0]  col_ram   [abtv_pkg::BankDepth];
  logic [7:0]  wrk_ram   [abtv_pkg::BankDepth];
  logic [7:0]  pat_bytes [abtv_pkg::PatDepth];
  logic [23:0] shades    [8];
  logic        irq_latch;
  logic [3:0]  scroll_latch;
  logic [7:0]  palette_latch;
  logic [7:0]  melody_byte;
  logic [7:0]  noise_byte;
  logic [7:0]  dip_byte;
  abtv_pkg::out_item_t owed_words [$];
  int unsigned faults;

  function new();
    foreach (rom_bytes[i]) rom_bytes[i] = abtv_pkg::ROM_FILL;
    foreach (fg_map[i]) begin
      fg_map[i]  = '0;
      bg_map[i]  = '0;
      col_ram[i] = '0;
      wrk_ram[i] = '0;
    end
    foreach (pat_bytes[i]) pat_bytes[i] = '0;
    shades = '{24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
               24'hAA0000, 24'hAA00AA, 24'hAAAA00, 24'hAAAAAA};
    irq_latch     = 1'b0;
    scroll_latch  = '0;
    palette_latch = '0;
    melody_byte   = '0;
    noise_byte    = '0;
    dip_byte      = '0;
    faults        = 0;
  endfunction

  function void set_dip(logic [7:0] v);
    dip_byte = v;
  endfunction

  // Read or write one RAM bank of the 0x4000 page; returns the old byte
  function logic [7:0] bank_access(logic [1:0] sel, logic [9:0] off, bit wr,
                                   logic [7:0] v);
    logic [7:0] old;
    case (sel)
      abtv_pkg::BANK_FG: begin
        old = fg_map[off];
        if (wr) fg_map[off] = v;
      end
      abtv_pkg::BANK_BG: begin
        old = bg_map[off];
        if (wr) bg_map[off] = v;
      end
      abtv_pkg::BANK_COL: begin
        old = col_ram[off];
        if (wr) col_ram[off] = v;
      end
      default: begin
        old = wrk_ram[off];
        if (wr) wrk_ram[off] = v;
      end
    endcase
    return old;
  endfunction

  // Work out the result of one word and advance the board state
  function abtv_pkg::out_item_t board_response(abtv_pkg::in_item_t w);
    abtv_pkg::out_item_t r;
    logic [7:0] tile;
    logic [7:0] row;
    logic [7:0] attr;
    logic [7:0] old;
    bit         in_page;
    r = '0;
    in_page = (w.address[15:12] == abtv_pkg::BANK_PAGE);
    case (w.kind)
      abtv_pkg::KIND_MEM_RD: begin
        if (w.address < abtv_pkg::RomDepth)
          r.read_data = rom_bytes[w.address[12:0]];
        else if (in_page)
          r.read_data = bank_access(w.address[11:10], w.address[9:0], 1'b0, 8'h00);
        else
          r.read_data = abtv_pkg::UNMAPPED;
      end
      abtv_pkg::KIND_MEM_WR: begin
        // ROM and holes in the map swallow the write
        if (in_page) old = bank_access(w.address[11:10], w.address[9:0], 1'b1, w.data);
      end
      abtv_pkg::KIND_IO_IN: begin
        case (w.port)
          abtv_pkg::PORT_P1:   r.read_data = ~w.p1_buttons;
          abtv_pkg::PORT_P2:   r.read_data = ~w.p2_buttons;
          abtv_pkg::PORT_DIP:  r.read_data = dip_byte;
          abtv_pkg::PORT_COIN: r.read_data = w.coin_inputs;
          default:             r.read_data = abtv_pkg::UNMAPPED;
        endcase
      end
      abtv_pkg::KIND_IO_OUT: begin
        case (w.port)
          abtv_pkg::PORT_PALETTE: palette_latch = w.data;
          abtv_pkg::PORT_MELODY:  melody_byte   = w.data;
          abtv_pkg::PORT_NOISE:   noise_byte    = w.data;
          abtv_pkg::PORT_CONTROL: begin
            irq_latch    = w.data[0];
            scroll_latch = w.data[4:1];
          end
          default: ;
        endcase
      end
      abtv_pkg::KIND_ROM_LOAD: begin
        if (w.address < abtv_pkg::RomDepth) rom_bytes[w.address[12:0]] = w.data;
      end
      abtv_pkg::KIND_PAT_LOAD: begin
        if (w.address < abtv_pkg::PatDepth) pat_bytes[w.address[11:0]] = w.data;
      end
      abtv_pkg::KIND_PIXEL: begin
        if (w.pixel_x < abtv_pkg::ScreenWidth && w.pixel_y < abtv_pkg::ScreenHeight) begin
          tile = fg_map[{w.pixel_y[7:3], w.pixel_x[7:3]}];
          row  = pat_bytes[{1'b0, tile, w.pixel_y[2:0]}];
          attr = col_ram[{5'd0, w.pixel_x[7:3]}];
          r.pixel_color = row[~w.pixel_x[2:0]] ? shades[attr[2:0]] : shades[attr[6:4]];
        end
      end
      default: ;
    endcase
    r.irq_en         = irq_latch;
    r.scroll_ofs     = scroll_latch;
    r.palette_select = palette_latch;
    r.melody_code    = melody_byte;
    r.noise_code     = noise_byte;
    return r;
  endfunction

  function void note_word(abtv_pkg::in_item_t w);
    owed_words.push_back(board_response(w));
  endfunction

  function void compare(string what, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      faults++;
    end
  endfunction

  function void check_word(abtv_pkg::out_item_t got);
    abtv_pkg::out_item_t want;
    if (owed_words.size() == 0) begin
      $display("%0t: result word with none owed, expected nothing got %h", $time, got);
      faults++;
      return;
    end
    want = owed_words.pop_front();
    compare("read_data", 24'(want.read_data), 24'(got.read_data));
    compare("pixel_color", want.pixel_color, got.pixel_color);
    compare("irq_en", 24'(want.irq_en), 24'(got.irq_en));
    compare("scroll_ofs", 24'(want.scroll_ofs), 24'(got.scroll_ofs));
    compare("palette_select", 24'(want.palette_select), 24'(got.palette_select));
    compare("melody_code", 24'(want.melody_code), 24'(got.melody_code));
    compare("noise_code", 24'(want.noise_code), 24'(got.noise_code));
  endfunction
endclass

module testbench;

  localparam logic [2:0]  KIND_SPARE  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [abtv_pkg::CfgAw-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  int unsigned                send_idle_pct;
  int unsigned                recv_idle_pct;
  int unsigned                cycles;
  bus_video_ledger            ledger = new();

  abtv_in_if  req_if ();
  abtv_out_if rsp_if ();

  arcade_board_bus_and_tile_video_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Give up on a hung unit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Note accepted requests and check accepted results
  always @(posedge clk_i) begin
    abtv_pkg::in_item_t  seen;
    abtv_pkg::out_item_t got;
    if (rst_ni && req_if.valid && req_if.ready) begin
      seen = {req_if.kind, req_if.address, req_if.data, req_if.port, req_if.pixel_x,
              req_if.pixel_y, req_if.p1_buttons, req_if.p2_buttons, req_if.coin_inputs};
      ledger.note_word(seen);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.read_data, rsp_if.pixel_color, rsp_if.irq_en, rsp_if.scroll_ofs,
             rsp_if.palette_select, rsp_if.melody_code, rsp_if.noise_code};
      ledger.check_word(got);
    end
  end

  function automatic logic [15:0] bank_addr(logic [1:0] sel, logic [9:0] off);
    return {abtv_pkg::BANK_PAGE, sel, off};
  endfunction

  // Build a word with random button and coin bytes
  function automatic abtv_pkg::in_item_t make_word(logic [2:0] kind, logic [15:0] addr,
                                                   logic [7:0] data, logic [7:0] port,
                                                   logic [7:0] x, logic [7:0] y);
    abtv_pkg::in_item_t w;
    w.kind        = kind;
    w.address     = addr;
    w.data        = data;
    w.port        = port;
    w.pixel_x     = x;
    w.pixel_y     = y;
    w.p1_buttons  = 8'($urandom);
    w.p2_buttons  = 8'($urandom);
    w.coin_inputs = 8'($urandom);
    return w;
  endfunction

  // Mostly well-formed traffic aimed at a small hot corner of the screen
  // so that map, pattern and colour writes show up in later pixels
  function automatic abtv_pkg::in_item_t random_word();
    abtv_pkg::in_item_t w;
    int unsigned        pick;
    logic [1:0]         sel;
    logic [9:0]         off;
    bit                 hot;
    w = make_word(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    hot  = $urandom_range(0, 1);
    sel  = 2'($urandom_range(0, 3));
    off  = hot ? 10'(($urandom_range(0, 3) << 5) | $urandom_range(0, 3))
               : 10'($urandom_range(0, 1023));
    if (pick < 14) begin
      w.kind    = abtv_pkg::KIND_MEM_WR;
      w.address = bank_addr(sel, off);
      if (sel == abtv_pkg::BANK_FG && hot) w.data = 8'($urandom_range(0, 31));
    end else if (pick < 20) begin
      w.kind = abtv_pkg::KIND_MEM_WR;
    end else if (pick < 30) begin
      w.kind    = abtv_pkg::KIND_MEM_RD;
      w.address = hot ? 16'($urandom_range(0, abtv_pkg::RomDepth - 1))
                      : bank_addr(sel, off);
    end else if (pick < 35) begin
      w.kind = abtv_pkg::KIND_MEM_RD;
    end else if (pick < 43) begin
      w.kind = abtv_pkg::KIND_IO_IN;
      if ($urandom_range(0, 4) != 0) w.port = 8'($urandom_range(0, 3));
    end else if (pick < 51) begin
      w.kind = abtv_pkg::KIND_IO_OUT;
      if ($urandom_range(0, 4) != 0) w.port = 8'($urandom_range(4, 7));
    end else if (pick < 58) begin
      w.kind = abtv_pkg::KIND_ROM_LOAD;
      if ($urandom_range(0, 6) != 0)
        w.address = 16'($urandom_range(0, abtv_pkg::RomDepth - 1));
    end else if (pick < 68) begin
      w.kind = abtv_pkg::KIND_PAT_LOAD;
      if ($urandom_range(0, 6) != 0)
        w.address = hot ? 16'($urandom_range(0, 255))
                        : 16'($urandom_range(0, abtv_pkg::PatDepth - 1));
    end else if (pick < 96) begin
      w.kind = abtv_pkg::KIND_PIXEL;
      if (hot) begin
        w.pixel_x = 8'($urandom_range(0, 31));
        w.pixel_y = 8'($urandom_range(0, 31));
      end
    end else begin
      w.kind = KIND_SPARE;
    end
    return w;
  endfunction

  // Present one word, idling first at random; return at the falling edge after acceptance
  task automatic send_word(abtv_pkg::in_item_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.kind        <= w.kind;
    req_if.address     <= w.address;
    req_if.data        <= w.data;
    req_if.port        <= w.port;
    req_if.pixel_x     <= w.pixel_x;
    req_if.pixel_y     <= w.pixel_y;
    req_if.p1_buttons  <= w.p1_buttons;
    req_if.p2_buttons  <= w.p2_buttons;
    req_if.coin_inputs <= w.coin_inputs;
    req_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed result has been taken
  task automatic drain();
    req_if.valid <= 1'b0;
    while (ledger.owed_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the DIP byte: setup cycle, then access cycle
  task automatic write_dip(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {abtv_pkg::REG_DIP, 2'b00};
    pwdata  <= {24'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.set_dip(v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count, int unsigned s_pct, int unsigned r_pct,
                              bit with_pause);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (with_pause && i == count / 2) drain();
      send_word(random_word());
    end
  endtask

  initial begin
    abtv_pkg::in_item_t edge_words [$];
    rst_ni             = 1'b0;
    cycles             = 0;
    send_idle_pct      = 28;
    recv_idle_pct      = 75;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.kind        = '0;
    req_if.address     = '0;
    req_if.data        = '0;
    req_if.port        = '0;
    req_if.pixel_x     = '0;
    req_if.pixel_y     = '0;
    req_if.p1_buttons  = '0;
    req_if.p2_buttons  = '0;
    req_if.coin_inputs = '0;
    rsp_if.ready       = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    write_dip(8'hC3);

    // ROM limits: fresh fill, loads at both ends, loads past the end ignored
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_RD, 16'h0000,
                                   8'h00, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_ROM_LOAD, 16'h0000,
                                   8'hA5, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_ROM_LOAD, 16'h1FFF,
                                   8'h00, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_ROM_LOAD, 16'h2000,
                                   8'h11, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_RD, 16'h0000,
                                   8'h00, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_RD, 16'h1FFF,
                                   8'h00, 8'h00, 8'h00, 8'h00));
    // writes to ROM and to holes in the map go nowhere
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_WR, 16'h0000,
                                   8'h5A, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_WR, 16'hFFFF,
                                   8'h5A, 8'h00, 8'h00, 8'h00));
    // first and last byte of the RAM banks, then unmapped reads
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_WR,
                                   bank_addr(abtv_pkg::BANK_FG, 10'd0),
                                   8'h01, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_WR,
                                   bank_addr(abtv_pkg::BANK_BG, 10'h3FF),
                                   8'h3C, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_WR,
                                   bank_addr(abtv_pkg::BANK_COL, 10'd0),
                                   8'h71, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_WR,
                                   bank_addr(abtv_pkg::BANK_WORK, 10'h3FF),
                                   8'hFF, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_RD,
                                   bank_addr(abtv_pkg::BANK_BG, 10'h3FF),
                                   8'h00, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_RD,
                                   bank_addr(abtv_pkg::BANK_WORK, 10'h3FF),
                                   8'h00, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_RD, 16'h2000,
                                   8'h00, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_MEM_RD, 16'hFFFF,
                                   8'h00, 8'h00, 8'h00, 8'h00));
    // pattern limits, then ink and paper of tile one and the far corner
    edge_words.push_back(make_word(abtv_pkg::KIND_PAT_LOAD, 16'h0008,
                                   8'h80, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_PAT_LOAD, 16'h0FFF,
                                   8'hFF, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_PAT_LOAD, 16'h1000,
                                   8'h55, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_PIXEL, 16'h0000,
                                   8'h00, 8'h00, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_PIXEL, 16'h0000,
                                   8'h00, 8'h00, 8'h01, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_PIXEL, 16'h0000,
                                   8'h00, 8'h00, 8'hFF, 8'hFF));
    // every input port and an unmapped one
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_IN, 16'h0000,
                                   8'h00, abtv_pkg::PORT_P1, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_IN, 16'h0000,
                                   8'h00, abtv_pkg::PORT_P2, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_IN, 16'h0000,
                                   8'h00, abtv_pkg::PORT_DIP, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_IN, 16'h0000,
                                   8'h00, abtv_pkg::PORT_COIN, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_IN, 16'h0000,
                                   8'h00, 8'hFF, 8'h00, 8'h00));
    // every output port, an unmapped one, and the spare kind
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_OUT, 16'h0000,
                                   8'hFF, abtv_pkg::PORT_PALETTE, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_OUT, 16'h0000,
                                   8'hFF, abtv_pkg::PORT_MELODY, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_OUT, 16'h0000,
                                   8'hFF, abtv_pkg::PORT_NOISE, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_OUT, 16'h0000,
                                   8'hFF, abtv_pkg::PORT_CONTROL, 8'h00, 8'h00));
    edge_words.push_back(make_word(abtv_pkg::KIND_IO_OUT, 16'h0000,
                                   8'h00, 8'hFF, 8'h00, 8'h00));
    edge_words.push_back(make_word(KIND_SPARE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    foreach (edge_words[i]) send_word(edge_words[i]);
    drain();

    random_phase(330, 28, 75, 1'b1);
    drain();
    write_dip(8'hFF);
    random_phase(330, 75, 28, 1'b0);
    drain();
    write_dip(8'h00);
    random_phase(340, 0, 0, 1'b0);
    drain();
    repeat (8) @(negedge clk_i);

    if (ledger.faults == 0 && ledger.owed_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
